// File: hdl/hss_pkg.sv
// Shared types, codes and constants of the half-step stepper controller.
package hss_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int RATE_W   = 10;
  localparam int GAP_W    = 10;
  localparam int ADD_W    = RATE_W + GAP_W;
  localparam int CREDIT_W = 11;

  localparam logic [RATE_W-1:0]   RATE_RESET      = 10'd500;
  localparam logic [RATE_W-1:0]   RATE_MIN        = 10'd1;
  localparam logic [RATE_W-1:0]   RATE_MAX        = 10'd1000;
  localparam logic [GAP_W-1:0]    GAP_CAP         = 10'd1000;
  localparam logic [CREDIT_W-1:0] CREDIT_PER_STEP = 11'd1000;
  localparam logic [CREDIT_W-1:0] CREDIT_MOVING   = 11'd1999;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_MOVE_ABS = 3'd1,
    REQ_MOVE_REL = 3'd2,
    REQ_STOP     = 3'd3,
    REQ_HOLD     = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_MOVE_ABS,
    OP_MOVE_REL,
    OP_STOP,
    OP_HOLD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADD_W-1:0]   credit_add;
    logic signed [31:0] move_amount;
    logic               hold_on;
  } hss_entry_t;

  function automatic logic [3:0] phase_pattern(input logic [2:0] phase);
    logic [3:0] p;
    case (phase)
      3'd0: p = 4'h8;
      3'd1: p = 4'hC;
      3'd2: p = 4'h4;
      3'd3: p = 4'h6;
      3'd4: p = 4'h2;
      3'd5: p = 4'h3;
      3'd6: p = 4'h1;
      3'd7: p = 4'h9;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/hss_if.sv
// Request and response channel interfaces of the stepper controller.
interface hss_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        time_ms;
  logic signed [31:0] move_amount;
  logic               hold_on;

  modport source(output valid, output req_type, output time_ms, output move_amount,
                 output hold_on, input ready);
  modport sink(input valid, input req_type, input time_ms, input move_amount,
               input hold_on, output ready);
endinterface

interface hss_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_pattern;
  logic signed [31:0] current_position;
  logic               is_moving;
  logic               coils_on;

  modport source(output valid, output coil_pattern, output current_position,
                 output is_moving, output coils_on, input ready);
  modport sink(input valid, input coil_pattern, input current_position,
               input is_moving, input coils_on, output ready);
endinterface

// File: hdl/half_step_stepper_controller_top.sv
// Top level of the half-step unipolar stepper controller.
// A request is written into the queue at its transfer, then the back end executes it
//   into the result register. Throughput: one request per cycle while the queue is not full;
//   the back end executes one queued command per cycle while rsp is idle or being taken.
// Reset (rst, synchronous): position, target, time base and flags clear, credit
//   is one full step, rate returns to 500 half steps per second, queue empties.
module half_step_stepper_controller_top import hss_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  hss_req_if.sink    req,
  hss_rsp_if.source  rsp
);

  // Front end decodes each request and turns a tick into a credit increment
  // (capped gap times rate), so the back end only adds, compares and steps.
  logic       push;
  logic       full;
  hss_entry_t front_entry;

  // Queue lets the front keep taking transfers while the back waits on rsp.ready.
  logic       pop;
  logic       not_empty;
  hss_entry_t head;

  hss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .full      (full),
    .push      (push),
    .entry     (front_entry)
  );

  hss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head       (head)
  );

  // Back end owns position, target, credit and coil state; it advances only
  // when its result register is empty or being taken in the same cycle.
  hss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

// File: hdl/hss_front.sv
// Front end: accepts requests, decodes them and precomputes tick credit.
module hss_front import hss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  hss_req_if.sink    req,
  input  logic       full,
  output logic       push,
  output hss_entry_t entry
);

  logic [RATE_W-1:0] step_rate;
  logic [31:0]       last_tick;
  logic [31:0]       gap;
  logic [GAP_W-1:0]  gap_capped;

  assign req.ready = !full;
  assign push      = req.valid && !full;

  // Clamp the written rate to its legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate <= RATE_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata < RATE_MIN) begin
        step_rate <= RATE_MIN;
      end else if (cfg_wdata > RATE_MAX) begin
        step_rate <= RATE_MAX;
      end else begin
        step_rate <= cfg_wdata;
      end
    end
  end

  // Every accepted tick moves the time base, whatever the back end does.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick <= '0;
    end else if (push && req.req_type == REQ_TICK) begin
      last_tick <= req.time_ms;
    end
  end

  always_comb begin
    gap        = req.time_ms - last_tick;
    gap_capped = (gap > 32'(GAP_CAP)) ? GAP_CAP : gap[GAP_W-1:0];

    entry.credit_add  = ADD_W'(gap_capped) * ADD_W'(step_rate);
    entry.move_amount = req.move_amount;
    entry.hold_on     = req.hold_on;
    case (req.req_type)
      REQ_TICK:     entry.op = OP_TICK;
      REQ_MOVE_ABS: entry.op = OP_MOVE_ABS;
      REQ_MOVE_REL: entry.op = OP_MOVE_REL;
      REQ_STOP:     entry.op = OP_STOP;
      REQ_HOLD:     entry.op = OP_HOLD;
      default:      entry.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/hss_queue.sv
// Short command queue between the front and back ends.
module hss_queue import hss_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hss_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output hss_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hss_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/hss_back.sv
// Back end: carries out queued commands on the motor state, registers results.
module hss_back import hss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       not_empty,
  input  hss_entry_t head,
  output logic       pop,
  hss_rsp_if.source  rsp
);

  logic [31:0]         step_position, step_position_next;
  logic [31:0]         target_position, target_position_next;
  logic [CREDIT_W-1:0] step_credit, step_credit_next;
  logic                hold_flag, hold_flag_next;
  logic                energized_flag, energized_flag_next;
  logic                starting_flag, starting_flag_next;
  logic [3:0]          coil_register, coil_register_next;

  logic                moving;
  logic [CREDIT_W-1:0] most;
  logic [ADD_W:0]      sum;
  logic [CREDIT_W-1:0] capped;
  logic [31:0]         stepped;

  assign pop    = not_empty && (!rsp.valid || rsp.ready);
  assign moving = (step_position != target_position);

  always_comb begin
    most    = (starting_flag || !moving) ? CREDIT_PER_STEP : CREDIT_MOVING;
    sum     = (ADD_W+1)'(step_credit) + (ADD_W+1)'(head.credit_add);
    capped  = (sum < (ADD_W+1)'(most)) ? sum[CREDIT_W-1:0] : most;
    stepped = ($signed(target_position) > $signed(step_position)) ?
              step_position + 32'd1 : step_position - 32'd1;

    step_position_next   = step_position;
    target_position_next = target_position;
    step_credit_next     = step_credit;
    hold_flag_next       = hold_flag;
    energized_flag_next  = energized_flag;
    starting_flag_next   = starting_flag;
    coil_register_next   = coil_register;

    case (head.op)
      OP_TICK: begin
        starting_flag_next = 1'b0;
        step_credit_next   = capped;
        if (!moving) begin
          if (capped == CREDIT_PER_STEP && energized_flag && !hold_flag) begin
            coil_register_next  = 4'h0;
            energized_flag_next = 1'b0;
          end
        end else if (capped >= CREDIT_PER_STEP) begin
          step_credit_next    = capped - CREDIT_PER_STEP;
          step_position_next  = stepped;
          coil_register_next  = phase_pattern(stepped[2:0]);
          energized_flag_next = 1'b1;
        end
      end
      OP_MOVE_ABS: begin
        if (!moving) begin
          starting_flag_next = 1'b1;
        end
        target_position_next = head.move_amount;
      end
      OP_MOVE_REL: begin
        if (!moving) begin
          starting_flag_next = 1'b1;
        end
        target_position_next = target_position + head.move_amount;
      end
      OP_STOP: begin
        target_position_next = step_position;
        coil_register_next   = 4'h0;
        energized_flag_next  = 1'b0;
      end
      OP_HOLD: begin
        hold_flag_next = head.hold_on;
        if (!moving) begin
          coil_register_next  = head.hold_on ? phase_pattern(step_position[2:0]) : 4'h0;
          energized_flag_next = head.hold_on;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_position   <= '0;
      target_position <= '0;
      step_credit     <= CREDIT_PER_STEP;
      hold_flag       <= 1'b0;
      energized_flag  <= 1'b0;
      starting_flag   <= 1'b0;
      coil_register   <= '0;
    end else if (pop) begin
      step_position   <= step_position_next;
      target_position <= target_position_next;
      step_credit     <= step_credit_next;
      hold_flag       <= hold_flag_next;
      energized_flag  <= energized_flag_next;
      starting_flag   <= starting_flag_next;
      coil_register   <= coil_register_next;
    end
  end

  // Result register: load on every executed command, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pop) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.coil_pattern     <= coil_register_next;
      rsp.current_position <= step_position_next;
      rsp.is_moving        <= (step_position_next != target_position_next);
      rsp.coils_on         <= energized_flag_next;
    end
  end

endmodule
